// ----- sv/chw_pkg.sv -----
// shared types, constants and helpers for the cell weighted histogram
package chw_pkg;

	localparam int DEF_MAX_BINS          = 64;
	localparam int DEF_MAX_CELLS_PER_ROW = 256;
	localparam int DEF_MAX_WIDTH         = 2048;

	localparam int DIM_W      = 12;
	localparam int CELL_W     = 6;
	localparam int BLOG_W     = 3;
	localparam int CROW_W     = 12;
	localparam int CCOL_W     = 10;
	localparam int PROW_W     = 12;
	localparam int IC_W       = 5;
	localparam int BIN_ID_W   = 8;
	localparam int WEIGHT_W   = 16;
	localparam int BIN_IDX_W  = 6;
	localparam int TOTAL_W    = 32;
	localparam int NB_W       = 7;
	localparam int REG_ADDR_W = 4;
	localparam int APB_W      = 32;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 64;

	localparam logic [DIM_W-1:0]  RST_WIDTH  = 12'd64;
	localparam logic [DIM_W-1:0]  RST_HEIGHT = 12'd64;
	localparam logic [CELL_W-1:0] RST_CELL   = 6'd8;
	localparam logic [BLOG_W-1:0] RST_BLOG   = 3'd4;

	localparam logic [DIM_W-1:0]  MIN_DIM    = 12'd3;
	localparam logic [DIM_W-1:0]  MAX_HEIGHT = 12'd4095;
	localparam logic [CELL_W-1:0] MIN_CELL   = 6'd1;
	localparam logic [CELL_W-1:0] MAX_CELL   = 6'd32;
	localparam logic [BLOG_W-1:0] MAX_BLOG   = 3'd6;
	localparam logic [CCOL_W-1:0] CCOL_SAT   = 10'd1023;
	localparam logic [CROW_W-1:0] CROW_SAT   = 12'd4095;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_CELL_EDGE,
		REG_BINS_LOG2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN,
		ST_FL_READ,
		ST_FL_LOAD
	} state_t;

	// saturated configuration as the datapath uses it
	typedef struct packed {
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [CELL_W-1:0] c;
		logic [BLOG_W-1:0] lg;
	} cfg_t;

	// position info of the pixel at the input
	typedef struct packed {
		logic              hit;
		logic              flush;
		logic [CCOL_W-1:0] ccol;
		logic [CROW_W-1:0] crow;
	} pix_t;

	function automatic int addr_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// ----- sv/cell_weighted_histogram.sv -----
// top level: per-cell weighted histogram over a raster pixel stream
//
// Pixels enter on s_axis in raster order, one word per pixel (bin id, weight).
// Each accepted pixel reads its bin sum from the bin store, adds the weight
// with 32-bit saturation and writes it back in the cycle after; a pixel that
// reads the entry written in the cycle before gets the new sum forwarded.
// Pixels sustain one per cycle while no cell finishes.
// When a cell's bottom-right pixel is accepted, input stalls and the cell's
// bins are read out in bin order on m_axis, each cleared as it is read. Each
// bin passes two steps (store read, then load of the output register), and a
// stalled m_axis holds the flush, and with it the input, for the stall. The
// last bin of a cell carries tlast.
// After reset the store is swept to zero, one entry per cycle, over all
// MAX_CELLS_PER_ROW * MAX_BINS entries (16384 at the defaults);
// s_axis_tready stays low meanwhile. The apb port is usable at once; write
// it only between frames with no result pending.
module cell_weighted_histogram #(
	parameter int MAX_BINS          = chw_pkg::DEF_MAX_BINS,
	parameter int MAX_CELLS_PER_ROW = chw_pkg::DEF_MAX_CELLS_PER_ROW,
	parameter int MAX_WIDTH         = chw_pkg::DEF_MAX_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [chw_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // bin_id, weight
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// cell_row, cell_col, bin_index, bin_total, zero fill
	output logic [chw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                            m_axis_tlast,  // last_bin
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [chw_pkg::REG_ADDR_W-1:0]  paddr,
	input  logic [chw_pkg::APB_W-1:0]       pwdata,
	output logic [chw_pkg::APB_W-1:0]       prdata,
	output logic                            pready
);
	import chw_pkg::*;

	localparam int DEPTH = MAX_CELLS_PER_ROW * MAX_BINS;
	localparam int AW    = addr_w(DEPTH);
	localparam int BW    = addr_w(MAX_BINS);
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	cfg_t   cfg;
	pix_t   pix;
	state_t state_q, state_n;

	logic              accept;
	logic [NB_W-1:0]   nb_m1;
	logic [BIN_ID_W-1:0] bin_m;
	logic [AW-1:0]     base_in;
	logic [AW-1:0]     addr_in;

	logic              v_s1;
	logic              flush_s1;
	logic [AW-1:0]     addr_s1;
	logic [AW-1:0]     base_s1;
	logic signed [WEIGHT_W-1:0] wt_s1;
	logic [CCOL_W-1:0] ccol_s1;
	logic [CROW_W-1:0] crow_s1;

	logic [AW-1:0]     clr_q;
	logic [BW-1:0]     k_q;
	logic              last_k;
	logic [AW-1:0]     fl_addr;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [TOTAL_W-1:0] wdata;
	logic [TOTAL_W-1:0] rdata;
	logic              wr_v_q;
	logic [AW-1:0]     wr_addr_q;
	logic [TOTAL_W-1:0] wr_data_q;
	logic [TOTAL_W-1:0] rd_fwd;
	logic [TOTAL_W:0]  sum;
	logic [TOTAL_W-1:0] sat_sum;
	logic              out_load;

	logic              out_valid_q;
	logic [CROW_W-1:0] o_row_q;
	logic [CCOL_W-1:0] o_col_q;
	logic [BIN_IDX_W-1:0] o_bin_q;
	logic [TOTAL_W-1:0] o_total_q;
	logic              o_last_q;

	chw_cfg #(
		.MAX_BINS  (MAX_BINS),
		.MAX_WIDTH (MAX_WIDTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	chw_pos #(
		.MAX_CELLS_PER_ROW (MAX_CELLS_PER_ROW),
		.MAX_WIDTH         (MAX_WIDTH)
	) u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (accept),
		.pix     (pix)
	);

	chw_ram #(
		.WIDTH (TOTAL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign nb_m1   = NB_W'((NB_W'(1) << cfg.lg) - NB_W'(1));
	assign bin_m   = s_axis_tdata[BIN_ID_W-1:0] & BIN_ID_W'(nb_m1);
	assign base_in = AW'(pix.ccol) * AW'(MAX_BINS);
	assign addr_in = base_in + AW'(bin_m[BW-1:0]);
	assign fl_addr = base_s1 + AW'(k_q);
	assign last_k  = (NB_W'(k_q) == nb_m1);

	// read-first store: the entry written on the last edge comes from the bypass
	assign rd_fwd  = (wr_v_q && (wr_addr_q == addr_s1)) ? wr_data_q : rdata;
	assign sum     = {rd_fwd[TOTAL_W-1], rd_fwd} + (TOTAL_W + 1)'(wt_s1);
	assign sat_sum = (sum[TOTAL_W] != sum[TOTAL_W-1]) ?
	                 {sum[TOTAL_W], {(TOTAL_W - 1){~sum[TOTAL_W]}}} : sum[TOTAL_W-1:0];

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_CLEAR:   if (clr_q == CLR_LAST) state_n = ST_RUN;
			ST_RUN:     if (v_s1 && flush_s1) state_n = ST_FL_READ;
			ST_FL_READ: if (!out_valid_q || m_axis_tready) state_n = ST_FL_LOAD;
			ST_FL_LOAD: state_n = last_k ? ST_RUN : ST_FL_READ;
			default:    state_n = ST_CLEAR;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		we            = 1'b0;
		waddr         = addr_s1;
		wdata         = sat_sum;
		raddr         = addr_in;
		out_load      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_RUN: begin
				s_axis_tready = !(v_s1 && flush_s1);
				we            = v_s1;
			end
			ST_FL_READ: begin
				raddr = fl_addr;
			end
			ST_FL_LOAD: begin
				we       = 1'b1;
				waddr    = fl_addr;
				wdata    = '0;
				out_load = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			k_q         <= '0;
			v_s1        <= 1'b0;
			wr_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			v_s1    <= accept && pix.hit;
			wr_v_q  <= we;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (out_load) k_q <= last_k ? '0 : k_q + 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= waddr;
		wr_data_q <= wdata;
		if (accept) begin
			flush_s1 <= pix.flush;
			addr_s1  <= addr_in;
			base_s1  <= base_in;
			wt_s1    <= s_axis_tdata[BIN_ID_W +: WEIGHT_W];
			ccol_s1  <= pix.ccol;
			crow_s1  <= pix.crow;
		end
		if (out_load) begin
			o_row_q   <= crow_s1;
			o_col_q   <= ccol_s1;
			o_bin_q   <= BIN_IDX_W'(k_q);
			o_total_q <= rd_fwd;
			o_last_q  <= last_k;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {4'b0, o_total_q, o_bin_q, o_col_q, o_row_q};

	// the output register is always free when a flushed bin arrives
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FL_LOAD) |-> !out_valid_q)
		else $error("flushed bin loaded over a pending word");

	a_flush_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && state_n == ST_FL_READ) |=> (k_q == '0))
		else $error("flush did not start at bin zero");

	a_last_bin: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (NB_W'(o_bin_q) == nb_m1))
		else $error("tlast on a bin other than the last");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!m_axis_tvalid && !v_s1))
		else $error("activity during the clearing sweep");

endmodule

// ----- sv/chw_ram.sv -----
// generic single write port, single read port ram with registered read
module chw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [chw_pkg::addr_w(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]                  wdata,
	input  logic [chw_pkg::addr_w(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]                  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/chw_cfg.sv -----
// apb register file and saturation of the configuration values
module chw_cfg #(
	parameter int MAX_BINS  = chw_pkg::DEF_MAX_BINS,
	parameter int MAX_WIDTH = chw_pkg::DEF_MAX_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [chw_pkg::REG_ADDR_W-1:0]  paddr,
	input  logic [chw_pkg::APB_W-1:0]       pwdata,
	output logic [chw_pkg::APB_W-1:0]       prdata,
	output logic                            pready,
	output chw_pkg::cfg_t                   cfg
);
	import chw_pkg::*;

	localparam int BLG = $clog2(MAX_BINS + 1) - 1;
	localparam logic [BLOG_W-1:0] BLG_MAX = BLOG_W'(BLG);
	localparam logic [DIM_W-1:0]  W_MAX   = DIM_W'(MAX_WIDTH);

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [CELL_W-1:0] cell_q;
	logic [BLOG_W-1:0] blog_q;
	reg_idx_t          idx;
	logic              wr_en;
	logic [BLOG_W-1:0] lg6;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			cell_q   <= RST_CELL;
			blog_q   <= RST_BLOG;
		end else if (wr_en) begin
			case (idx)
				REG_IMAGE_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				REG_CELL_EDGE:    cell_q   <= pwdata[CELL_W-1:0];
				REG_BINS_LOG2:    blog_q   <= pwdata[BLOG_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_IMAGE_WIDTH:  prdata = APB_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = APB_W'(height_q);
			REG_CELL_EDGE:    prdata = APB_W'(cell_q);
			REG_BINS_LOG2:    prdata = APB_W'(blog_q);
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q < MIN_DIM)     cfg.w = MIN_DIM;
		else if (width_q > W_MAX)  cfg.w = W_MAX;
		else                       cfg.w = width_q;

		if (height_q < MIN_DIM)         cfg.h = MIN_DIM;
		else if (height_q > MAX_HEIGHT) cfg.h = MAX_HEIGHT;
		else                            cfg.h = height_q;

		if (cell_q < MIN_CELL)      cfg.c = MIN_CELL;
		else if (cell_q > MAX_CELL) cfg.c = MAX_CELL;
		else                        cfg.c = cell_q;

		lg6    = (blog_q > MAX_BLOG) ? MAX_BLOG : blog_q;
		// bin count may not pass the store's bins per cell
		cfg.lg = (lg6 > BLG_MAX) ? BLG_MAX : lg6;
	end

endmodule

// ----- sv/chw_pos.sv -----
// raster position counters and cell membership of the incoming pixel
module chw_pos #(
	parameter int MAX_CELLS_PER_ROW = chw_pkg::DEF_MAX_CELLS_PER_ROW,
	parameter int MAX_WIDTH         = chw_pkg::DEF_MAX_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  chw_pkg::cfg_t cfg,
	input  logic          advance,
	output chw_pkg::pix_t pix
);
	import chw_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [CW-1:0]     pcol_q;
	logic [PROW_W-1:0] prow_q;
	logic [IC_W-1:0]   cic_q;
	logic [IC_W-1:0]   ric_q;
	logic [CCOL_W-1:0] ccol_q;
	logic [CROW_W-1:0] crow_q;

	logic [DIM_W-1:0]  w1;
	logic [DIM_W-1:0]  h1;
	logic [CELL_W-1:0] c1;
	logic [16:0]       col_end;
	logic [18:0]       row_end;
	logic              col_ok;
	logic              row_ok;

	assign w1 = cfg.w - 1'b1;
	assign h1 = cfg.h - 1'b1;
	assign c1 = cfg.c - 1'b1;

	// a cell is whole when its far edge stays within the image less two pixels
	assign col_end = 17'({1'b0, ccol_q} + 11'd1) * 17'(cfg.c);
	assign row_end = 19'({1'b0, crow_q} + 13'd1) * 19'(cfg.c);
	assign col_ok  = (col_end <= 17'(cfg.w - 12'd2));
	assign row_ok  = (row_end <= 19'(cfg.h - 12'd2));

	always_comb begin
		pix.hit   = (prow_q != '0) && (pcol_q != '0) && col_ok && row_ok &&
		            ({1'b0, ccol_q} < 11'(MAX_CELLS_PER_ROW)) && (ccol_q != CCOL_SAT);
		pix.flush = (CELL_W'(cic_q) == c1) && (CELL_W'(ric_q) == c1);
		pix.ccol  = ccol_q;
		pix.crow  = crow_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcol_q <= '0;
			prow_q <= '0;
			cic_q  <= '0;
			ric_q  <= '0;
			ccol_q <= '0;
			crow_q <= '0;
		end else if (advance) begin
			if (DIM_W'(pcol_q) >= w1) begin
				pcol_q <= '0;
				cic_q  <= '0;
				ccol_q <= '0;
				if (prow_q >= h1) begin
					prow_q <= '0;
					ric_q  <= '0;
					crow_q <= '0;
				end else begin
					if (prow_q != '0) begin
						if (CELL_W'(ric_q) >= c1) begin
							ric_q <= '0;
							if (crow_q != CROW_SAT) crow_q <= crow_q + 1'b1;
						end else begin
							ric_q <= ric_q + 1'b1;
						end
					end
					prow_q <= prow_q + 1'b1;
				end
			end else begin
				if (pcol_q != '0) begin
					if (CELL_W'(cic_q) >= c1) begin
						cic_q <= '0;
						if (ccol_q != CCOL_SAT) ccol_q <= ccol_q + 1'b1;
					end else begin
						cic_q <= cic_q + 1'b1;
					end
				end
				pcol_q <= pcol_q + 1'b1;
			end
		end
	end

endmodule
